[rtl/core/wev_pkg.sv]
// Shared types, widths and constants of the wheel encoder velocity filter.
package wev_pkg;

   // Geometry and field widths
   localparam int WHEELS     = 4;
   localparam int COUNT_W    = 32;
   localparam int RPT_W      = 32;
   localparam int ALPHA_W    = 17;
   localparam int MASK_W     = 4;
   localparam int ELAPSED_W  = 24;
   localparam int POS_W      = 48;
   localparam int VEL_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Fixed-point constants
   localparam int FRAC_W = 16;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

   // 1e6 / 2^16 = 15625 / 2^10: scale the tick product before dividing by elapsed_us
   localparam int SCALE_MUL_W = 14;
   localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = SCALE_MUL_W'(15625);
   localparam int SCALE_SHIFT = 10;
   localparam int PROD_W      = COUNT_W + RPT_W;
   localparam int SCALED_W    = PROD_W + SCALE_MUL_W;
   localparam int DVD_W       = SCALED_W - SCALE_SHIFT - 1;

   // Divider: one quotient bit per cycle
   localparam int DIV_STEPS = DVD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RAD_PER_TICK = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_MASK  = CSR_IDX_W'(2);

   // Register reset values
   localparam logic [RPT_W-1:0]   RPT_RESET   = RPT_W'(6588397);
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(32768);
   localparam logic [MASK_W-1:0]  MASK_RESET  = MASK_W'(2);

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_MUL,
      ST_SCALE,
      ST_DIV,
      ST_SAT,
      ST_MIX,
      ST_UPD,
      ST_POS
   } state_type;

   // Step strobes from the sequencer to every lane
   typedef struct packed {
      logic capture;
      logic delta;
      logic mul;
      logic scale;
      logic div;
      logic sat;
      logic mix;
      logic upd;
   } ctl_type;

endpackage

[rtl/core/wev_lane.sv]
// One wheel's datapath: count delta, speed divider, smoothing filter and angle.
module wev_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  wev_pkg::ctl_type              ctl,
   input  logic [wev_pkg::COUNT_W-1:0]   count,
   input  logic                          invert,
   input  logic [wev_pkg::RPT_W-1:0]     rad_per_tick,
   input  logic [wev_pkg::ALPHA_W-1:0]   alpha,
   input  logic [wev_pkg::ELAPSED_W-1:0] elapsed,
   output logic [wev_pkg::POS_W-1:0]     position,
   output logic [wev_pkg::VEL_W-1:0]     velocity
);

   // State kept across samples
   logic [wev_pkg::COUNT_W-1:0] last_ff, last_in;
   logic [wev_pkg::VEL_W-1:0]   filt_ff, filt_in;

   // Per-sample working registers
   logic [wev_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                          neg_ff, neg_in;
   logic [wev_pkg::COUNT_W-1:0]   mag_ff, mag_in;
   logic [wev_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [wev_pkg::DVD_W-1:0]     dvd_ff, dvd_in;
   logic [wev_pkg::ELAPSED_W-1:0] rem_ff, rem_in;
   logic [wev_pkg::VEL_W-1:0]     quo_ff, quo_in;
   logic                          big_ff, big_in;
   logic [wev_pkg::VEL_W-1:0]     raw_ff, raw_in;
   logic signed [wev_pkg::VEL_W+wev_pkg::ALPHA_W+1:0] mix_ff, mix_in;

   // Combinational helpers
   logic [wev_pkg::COUNT_W-1:0]    diff;
   logic [wev_pkg::SCALED_W-1:0]   scaled;
   logic [wev_pkg::ELAPSED_W:0]    trial;
   logic [wev_pkg::ELAPSED_W:0]    trial_sub;
   logic                           qbit;
   logic [wev_pkg::VEL_W-1:0]      limit;
   logic [wev_pkg::VEL_W-1:0]      qsat;
   logic signed [wev_pkg::VEL_W:0] step_diff;
   logic signed [wev_pkg::ALPHA_W:0] alpha_s;
   logic signed [wev_pkg::COUNT_W+wev_pkg::RPT_W:0] pos_full;

   always_comb begin
      // Wrapped count change and its magnitude
      diff = cnt_ff - last_ff;

      // Tick product times 1e6 / 2^16
      scaled = {{wev_pkg::SCALE_MUL_W{1'b0}}, prod_ff}
             * {{wev_pkg::PROD_W{1'b0}}, wev_pkg::SCALE_MUL};

      // Restoring divide step by elapsed_us
      trial     = {rem_ff, dvd_ff[wev_pkg::DVD_W-1]};
      qbit      = (trial >= {1'b0, elapsed});
      trial_sub = qbit ? (trial - {1'b0, elapsed}) : trial;

      // Saturate to the signed speed range
      limit = neg_ff ? {1'b1, {(wev_pkg::VEL_W-1){1'b0}}} : {1'b0, {(wev_pkg::VEL_W-1){1'b1}}};
      qsat  = (big_ff || (quo_ff > limit)) ? limit : quo_ff;

      // Filter step: old + alpha * (raw - old) / 2^16
      step_diff = $signed({raw_ff[wev_pkg::VEL_W-1], raw_ff})
                - $signed({filt_ff[wev_pkg::VEL_W-1], filt_ff});
      alpha_s   = $signed({1'b0, alpha});

      // Angle of the stored count
      pos_full = $signed(last_ff) * $signed({1'b0, rad_per_tick});

      // Defaults: hold
      cnt_in  = cnt_ff;
      last_in = last_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      prod_in = prod_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      big_in  = big_ff;
      raw_in  = raw_ff;
      mix_in  = mix_ff;
      filt_in = filt_ff;

      if (ctl.capture) begin
         cnt_in = invert ? (~count + 1'b1) : count;
      end
      if (ctl.delta) begin
         neg_in  = diff[wev_pkg::COUNT_W-1];
         mag_in  = diff[wev_pkg::COUNT_W-1] ? (~diff + 1'b1) : diff;
         last_in = cnt_ff;
      end
      if (ctl.mul) begin
         prod_in = mag_ff * rad_per_tick;
      end
      if (ctl.scale) begin
         dvd_in = scaled[wev_pkg::SCALED_W-2:wev_pkg::SCALE_SHIFT];
         rem_in = '0;
         quo_in = '0;
         big_in = 1'b0;
      end
      if (ctl.div) begin
         dvd_in = {dvd_ff[wev_pkg::DVD_W-2:0], 1'b0};
         rem_in = trial_sub[wev_pkg::ELAPSED_W-1:0];
         quo_in = {quo_ff[wev_pkg::VEL_W-2:0], qbit};
         big_in = big_ff | quo_ff[wev_pkg::VEL_W-1];
      end
      if (ctl.sat) begin
         raw_in = neg_ff ? (~qsat + 1'b1) : qsat;
      end
      if (ctl.mix) begin
         mix_in = step_diff * alpha_s;
      end
      if (ctl.upd) begin
         filt_in = filt_ff + mix_ff[wev_pkg::VEL_W+wev_pkg::FRAC_W-1:wev_pkg::FRAC_W];
      end
   end

   // Clear the kept state at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         filt_ff <= '0;
      end else begin
         last_ff <= last_in;
         filt_ff <= filt_in;
      end
   end

   // Working registers carry no reset
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      big_ff  <= big_in;
      raw_ff  <= raw_in;
      mix_ff  <= mix_in;
   end

   assign position = pos_full[wev_pkg::POS_W+wev_pkg::FRAC_W-1:wev_pkg::FRAC_W];
   assign velocity = filt_ff;

endmodule

[rtl/core/wev_ctrl.sv]
// Sequencer that steps all lanes together through one sample.
module wev_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             sample,
   input  logic             out_free,
   output logic             req_stall,
   output logic             out_load,
   output wev_pkg::ctl_type ctl
);

   localparam logic [wev_pkg::STEP_W-1:0] DIV_LAST = wev_pkg::STEP_W'(wev_pkg::DIV_STEPS - 1);

   wev_pkg::state_type state_ff, state_in;
   logic [wev_pkg::STEP_W-1:0] step_ff, step_in;

   // State and divide counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wev_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and step strobes
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      ctl       = '0;
      out_load  = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         wev_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = sample ? wev_pkg::ST_DELTA : wev_pkg::ST_POS;
            end
         end
         wev_pkg::ST_DELTA: begin
            ctl.delta = 1'b1;
            state_in  = wev_pkg::ST_MUL;
         end
         wev_pkg::ST_MUL: begin
            ctl.mul  = 1'b1;
            state_in = wev_pkg::ST_SCALE;
         end
         wev_pkg::ST_SCALE: begin
            ctl.scale = 1'b1;
            step_in   = '0;
            state_in  = wev_pkg::ST_DIV;
         end
         wev_pkg::ST_DIV: begin
            ctl.div = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = wev_pkg::ST_SAT;
            end
         end
         wev_pkg::ST_SAT: begin
            ctl.sat  = 1'b1;
            state_in = wev_pkg::ST_MIX;
         end
         wev_pkg::ST_MIX: begin
            ctl.mix  = 1'b1;
            state_in = wev_pkg::ST_UPD;
         end
         wev_pkg::ST_UPD: begin
            ctl.upd  = 1'b1;
            state_in = wev_pkg::ST_POS;
         end
         wev_pkg::ST_POS: begin
            // Hold until the result register is free
            if (out_free) begin
               out_load = 1'b1;
               state_in = wev_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wev_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/wheel_encoder_velocity_filter.sv]
// Top level: configuration registers, four wheel lanes, sequencer and result register.
//
// Usage
//   Request channel (req_*): four signed counter readings and elapsed_us, moved
//   by one transfer when req_valid is high and req_stall low. Response channel
//   (rsp_*): angles in Q32.16 rad, filtered speeds in Q16.16 rad/s and
//   sample_taken. Registers are written through csr_write_en / csr_index /
//   csr_data while no sample is in flight.
// Sequence
//   A sample with nonzero elapsed_us steps from its transfer to rsp_valid
//   through delta, multiply, scale, the per-lane restoring divider (one
//   quotient bit per cycle), saturate, filter, update and output.
//   A sample with elapsed_us of zero goes from its transfer straight to output.
//   One sample is in flight at a time; the next request is taken in the cycle
//   after the load, even while that result waits.
// Reset
//   Clears the stored counts and filtered speeds to zero, the registers to
//   their defaults and drops rsp_valid.
// Backpressure
//   While rsp_stall holds a result, it stays unchanged; a finished next
//   sample waits in its last step until the result register frees.
module wheel_encoder_velocity_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [wev_pkg::COUNT_W-1:0]   req_wheel_count_0,
   input  logic signed [wev_pkg::COUNT_W-1:0]   req_wheel_count_1,
   input  logic signed [wev_pkg::COUNT_W-1:0]   req_wheel_count_2,
   input  logic signed [wev_pkg::COUNT_W-1:0]   req_wheel_count_3,
   input  logic        [wev_pkg::ELAPSED_W-1:0] req_elapsed_us,
   // Response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [wev_pkg::POS_W-1:0]     rsp_wheel_position_0,
   output logic signed [wev_pkg::POS_W-1:0]     rsp_wheel_position_1,
   output logic signed [wev_pkg::POS_W-1:0]     rsp_wheel_position_2,
   output logic signed [wev_pkg::POS_W-1:0]     rsp_wheel_position_3,
   output logic signed [wev_pkg::VEL_W-1:0]     rsp_wheel_velocity_0,
   output logic signed [wev_pkg::VEL_W-1:0]     rsp_wheel_velocity_1,
   output logic signed [wev_pkg::VEL_W-1:0]     rsp_wheel_velocity_2,
   output logic signed [wev_pkg::VEL_W-1:0]     rsp_wheel_velocity_3,
   output logic                                 rsp_sample_taken,
   // Register write port
   input  logic                                 csr_write_en,
   input  logic        [wev_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [wev_pkg::CSR_DATA_W-1:0] csr_data
);

   // Configuration registers
   logic [wev_pkg::RPT_W-1:0]   rpt_ff, rpt_in;
   logic [wev_pkg::ALPHA_W-1:0] alpha_ff, alpha_in;
   logic [wev_pkg::MASK_W-1:0]  mask_ff, mask_in;

   // Sample-wide registers
   logic [wev_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                          sample_ff, sample_in;

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        taken_ff, taken_in;
   logic [wev_pkg::POS_W-1:0]   pos_ff [wev_pkg::WHEELS];
   logic [wev_pkg::VEL_W-1:0]   vel_ff [wev_pkg::WHEELS];

   // Lane connections
   logic [wev_pkg::COUNT_W-1:0] count_arr [wev_pkg::WHEELS];
   logic [wev_pkg::POS_W-1:0]   lane_pos  [wev_pkg::WHEELS];
   logic [wev_pkg::VEL_W-1:0]   lane_vel  [wev_pkg::WHEELS];

   wev_pkg::ctl_type ctl;
   logic             out_load;
   logic             out_free;
   logic             req_sample;
   logic [wev_pkg::ALPHA_W-1:0] csr_alpha;

   assign count_arr[0] = req_wheel_count_0;
   assign count_arr[1] = req_wheel_count_1;
   assign count_arr[2] = req_wheel_count_2;
   assign count_arr[3] = req_wheel_count_3;

   assign req_sample = (req_elapsed_us != '0);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Register writes; clamp alpha to one at write time
   always_comb begin
      csr_alpha = csr_data[wev_pkg::ALPHA_W-1:0];
      if (csr_alpha > wev_pkg::ALPHA_ONE) begin
         csr_alpha = wev_pkg::ALPHA_ONE;
      end
      rpt_in   = rpt_ff;
      alpha_in = alpha_ff;
      mask_in  = mask_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            wev_pkg::CSR_RAD_PER_TICK: rpt_in   = csr_data[wev_pkg::RPT_W-1:0];
            wev_pkg::CSR_FILTER_ALPHA: alpha_in = csr_alpha;
            wev_pkg::CSR_INVERT_MASK:  mask_in  = csr_data[wev_pkg::MASK_W-1:0];
            default: begin
               rpt_in = rpt_ff;
            end
         endcase
      end
   end

   // Capture sample-wide fields on transfer
   always_comb begin
      elapsed_in = elapsed_ff;
      sample_in  = sample_ff;
      if (ctl.capture) begin
         elapsed_in = req_elapsed_us;
         sample_in  = req_sample;
      end
   end

   // Result valid: set on load, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      taken_in     = taken_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         taken_in     = sample_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpt_ff       <= wev_pkg::RPT_RESET;
         alpha_ff     <= wev_pkg::ALPHA_RESET;
         mask_ff      <= wev_pkg::MASK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rpt_ff       <= rpt_in;
         alpha_ff     <= alpha_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      sample_ff  <= sample_in;
      taken_ff   <= taken_in;
   end

   // Sequencer
   wev_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sample    (req_sample),
      .out_free  (out_free),
      .req_stall (req_stall),
      .out_load  (out_load),
      .ctl       (ctl)
   );

   // One lane per wheel; merge their results into the result register
   for (genvar w = 0; w < wev_pkg::WHEELS; w++) begin : g_lane
      wev_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .count        (count_arr[w]),
         .invert       (mask_ff[w]),
         .rad_per_tick (rpt_ff),
         .alpha        (alpha_ff),
         .elapsed      (elapsed_ff),
         .position     (lane_pos[w]),
         .velocity     (lane_vel[w])
      );

      always_ff @(posedge clock) begin
         if (out_load) begin
            pos_ff[w] <= lane_pos[w];
            vel_ff[w] <= lane_vel[w];
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sample_taken     = taken_ff;
   assign rsp_wheel_position_0 = pos_ff[0];
   assign rsp_wheel_position_1 = pos_ff[1];
   assign rsp_wheel_position_2 = pos_ff[2];
   assign rsp_wheel_position_3 = pos_ff[3];
   assign rsp_wheel_velocity_0 = vel_ff[0];
   assign rsp_wheel_velocity_1 = vel_ff[1];
   assign rsp_wheel_velocity_2 = vel_ff[2];
   assign rsp_wheel_velocity_3 = vel_ff[3];

   // A result is never loaded over one that is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(out_load && rsp_valid_ff && rsp_stall))
      else $error("result loaded while previous result still stalled");

   // After a request transfer the block is busy in the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a sample is in flight");

   // A load raises rsp_valid in the next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded result not presented");

   // Stored alpha never exceeds one
   a_alpha_clamp: assert property (@(posedge clock) disable iff (reset)
      alpha_ff <= wev_pkg::ALPHA_ONE)
      else $error("filter weight above one");

endmodule

[bench/wev_velocity_checker.sv]
// Checker for the wheel encoder velocity filter: watches transfers, predicts and compares.
`timescale 1ns / 1ps

module wev_velocity_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [wev_pkg::COUNT_W-1:0]    req_wheel_count_0,
   input  logic signed [wev_pkg::COUNT_W-1:0]    req_wheel_count_1,
   input  logic signed [wev_pkg::COUNT_W-1:0]    req_wheel_count_2,
   input  logic signed [wev_pkg::COUNT_W-1:0]    req_wheel_count_3,
   input  logic        [wev_pkg::ELAPSED_W-1:0]  req_elapsed_us,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [wev_pkg::POS_W-1:0]      rsp_wheel_position_0,
   input  logic signed [wev_pkg::POS_W-1:0]      rsp_wheel_position_1,
   input  logic signed [wev_pkg::POS_W-1:0]      rsp_wheel_position_2,
   input  logic signed [wev_pkg::POS_W-1:0]      rsp_wheel_position_3,
   input  logic signed [wev_pkg::VEL_W-1:0]      rsp_wheel_velocity_0,
   input  logic signed [wev_pkg::VEL_W-1:0]      rsp_wheel_velocity_1,
   input  logic signed [wev_pkg::VEL_W-1:0]      rsp_wheel_velocity_2,
   input  logic signed [wev_pkg::VEL_W-1:0]      rsp_wheel_velocity_3,
   input  logic                                  rsp_sample_taken,
   input  logic                                  csr_write_en,
   input  logic        [wev_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [wev_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                    fail_count,
   output int                                    outstanding
);

   localparam longint US_PER_SECOND = 1000000;

   typedef struct packed {
      logic [wev_pkg::WHEELS-1:0][wev_pkg::POS_W-1:0] position;
      logic [wev_pkg::WHEELS-1:0][wev_pkg::VEL_W-1:0] velocity;
      logic                                           taken;
   } wheel_sample_type;

   // Shadow registers and filter state
   logic [wev_pkg::RPT_W-1:0]   rad_per_tick;
   logic [wev_pkg::ALPHA_W-1:0] alpha;
   logic [wev_pkg::MASK_W-1:0]  invert;
   logic [wev_pkg::COUNT_W-1:0] prev_count [wev_pkg::WHEELS];
   logic [wev_pkg::VEL_W-1:0]   smoothed [wev_pkg::WHEELS];
   wheel_sample_type            expected_samples [$];

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // Angle in Q32.16: floor of count times radians per tick over 2^16
   function automatic logic [wev_pkg::POS_W-1:0] angle_of(
         input logic [wev_pkg::COUNT_W-1:0] c,
         input logic [wev_pkg::RPT_W-1:0]   rpt);
      longint prod;
      prod = longint'($signed(c)) * longint'({32'd0, rpt});
      return wev_pkg::POS_W'(prod >>> wev_pkg::FRAC_W);
   endfunction

   // Unfiltered speed in Q16.16, truncated toward zero, then saturated
   function automatic longint speed_of(input logic [wev_pkg::COUNT_W-1:0]   delta,
                                       input logic [wev_pkg::ELAPSED_W-1:0] elapsed,
                                       input logic [wev_pkg::RPT_W-1:0]     rpt);
      logic                        neg;
      logic [wev_pkg::COUNT_W-1:0] mag;
      logic [127:0]                num;
      logic [127:0]                den;
      logic [127:0]                quo;
      logic [127:0]                cap;
      neg = delta[wev_pkg::COUNT_W-1];
      mag = neg ? -delta : delta;
      num = 128'(mag) * 128'(rpt) * 128'(US_PER_SECOND);
      den = 128'(elapsed) << wev_pkg::FRAC_W;
      quo = num / den;
      cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (quo > cap)
         quo = cap;
      return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
   endfunction

   // Advance the filter state by one sample and build the expected result
   task automatic predict_sample(
         input  logic [wev_pkg::WHEELS-1:0][wev_pkg::COUNT_W-1:0] counts,
         input  logic [wev_pkg::ELAPSED_W-1:0]                    elapsed,
         output wheel_sample_type                                 res);
      logic [wev_pkg::COUNT_W-1:0] c;
      longint                      a;
      longint                      raw;
      longint                      old;
      longint                      mixed;
      int                          i;
      a = (alpha > wev_pkg::ALPHA_ONE) ? longint'(wev_pkg::ALPHA_ONE) : longint'(alpha);
      for (i = 0; i < wev_pkg::WHEELS; i++) begin
         if (elapsed != 0) begin
            c = invert[i] ? -counts[i] : counts[i];
            raw = speed_of(c - prev_count[i], elapsed, rad_per_tick);
            prev_count[i] = c;
            old = longint'($signed(smoothed[i]));
            mixed = (a * raw + (longint'(wev_pkg::ALPHA_ONE) - a) * old)
                    >>> wev_pkg::FRAC_W;
            smoothed[i] = mixed[wev_pkg::VEL_W-1:0];
         end
         res.position[i] = angle_of(prev_count[i], rad_per_tick);
         res.velocity[i] = smoothed[i];
      end
      res.taken = (elapsed != 0);
   endtask

   always @(posedge clock) begin : watch
      wheel_sample_type                                 got;
      wheel_sample_type                                 want;
      logic [wev_pkg::WHEELS-1:0][wev_pkg::COUNT_W-1:0] counts;
      int                                               i;
      if (reset) begin
         rad_per_tick = wev_pkg::RPT_RESET;
         alpha        = wev_pkg::ALPHA_RESET;
         invert       = wev_pkg::MASK_RESET;
         for (i = 0; i < wev_pkg::WHEELS; i++) begin
            prev_count[i] = '0;
            smoothed[i]   = '0;
         end
         expected_samples.delete();
         fail_count = 0;
      end else begin
         // Compare a result transfer with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got.position = {rsp_wheel_position_3, rsp_wheel_position_2,
                            rsp_wheel_position_1, rsp_wheel_position_0};
            got.velocity = {rsp_wheel_velocity_3, rsp_wheel_velocity_2,
                            rsp_wheel_velocity_1, rsp_wheel_velocity_0};
            got.taken    = rsp_sample_taken;
            if (expected_samples.size() == 0) begin
               report_mismatch("result with no sample outstanding");
            end else begin
               want = expected_samples.pop_front();
               for (i = 0; i < wev_pkg::WHEELS; i++) begin
                  if (got.position[i] !== want.position[i])
                     report_mismatch($sformatf("wheel %0d position %h, expected %h",
                                               i, got.position[i], want.position[i]));
                  if (got.velocity[i] !== want.velocity[i])
                     report_mismatch($sformatf("wheel %0d velocity %h, expected %h",
                                               i, got.velocity[i], want.velocity[i]));
               end
               if (got.taken !== want.taken)
                  report_mismatch($sformatf("sample_taken %b, expected %b",
                                            got.taken, want.taken));
            end
         end
         // Track register writes
         if (csr_write_en) begin
            case (csr_index)
               wev_pkg::CSR_RAD_PER_TICK: rad_per_tick = csr_data[wev_pkg::RPT_W-1:0];
               wev_pkg::CSR_FILTER_ALPHA: alpha        = csr_data[wev_pkg::ALPHA_W-1:0];
               wev_pkg::CSR_INVERT_MASK:  invert       = csr_data[wev_pkg::MASK_W-1:0];
               default: ;
            endcase
         end
         // Predict each request transfer
         if (req_valid && !req_stall) begin
            counts = {req_wheel_count_3, req_wheel_count_2,
                      req_wheel_count_1, req_wheel_count_0};
            predict_sample(counts, req_elapsed_us, want);
            expected_samples.push_back(want);
         end
      end
      outstanding = expected_samples.size();
   end

endmodule

[bench/wheel_encoder_velocity_filter_test.sv]
// Top of the wheel encoder velocity filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module wheel_encoder_velocity_filter_test;

   localparam int STALL_LIMIT       = 2000;
   localparam int SETTLE_CYCLES     = 80;
   localparam int RANDOM_PHASES     = 31;
   localparam int SAMPLES_PER_PHASE = 50;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic signed [wev_pkg::COUNT_W-1:0]    req_wheel_count_0;
   logic signed [wev_pkg::COUNT_W-1:0]    req_wheel_count_1;
   logic signed [wev_pkg::COUNT_W-1:0]    req_wheel_count_2;
   logic signed [wev_pkg::COUNT_W-1:0]    req_wheel_count_3;
   logic        [wev_pkg::ELAPSED_W-1:0]  req_elapsed_us;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [wev_pkg::POS_W-1:0]      rsp_wheel_position_0;
   logic signed [wev_pkg::POS_W-1:0]      rsp_wheel_position_1;
   logic signed [wev_pkg::POS_W-1:0]      rsp_wheel_position_2;
   logic signed [wev_pkg::POS_W-1:0]      rsp_wheel_position_3;
   logic signed [wev_pkg::VEL_W-1:0]      rsp_wheel_velocity_0;
   logic signed [wev_pkg::VEL_W-1:0]      rsp_wheel_velocity_1;
   logic signed [wev_pkg::VEL_W-1:0]      rsp_wheel_velocity_2;
   logic signed [wev_pkg::VEL_W-1:0]      rsp_wheel_velocity_3;
   logic                                  rsp_sample_taken;
   logic                                  csr_write_en;
   logic        [wev_pkg::CSR_IDX_W-1:0]  csr_index;
   logic        [wev_pkg::CSR_DATA_W-1:0] csr_data;

   int                          fail_count;
   int                          outstanding;
   int                          quiet_cycles;
   int                          stall_left = 0;
   logic                        rsp_taken = 1'b0;
   logic                        stall_armed = 1'b0;
   bit                          req_idle_on;
   bit                          stall_on;
   logic [wev_pkg::COUNT_W-1:0] last_raw [wev_pkg::WHEELS];

   wheel_encoder_velocity_filter u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_wheel_count_0    (req_wheel_count_0),
      .req_wheel_count_1    (req_wheel_count_1),
      .req_wheel_count_2    (req_wheel_count_2),
      .req_wheel_count_3    (req_wheel_count_3),
      .req_elapsed_us       (req_elapsed_us),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_wheel_position_0 (rsp_wheel_position_0),
      .rsp_wheel_position_1 (rsp_wheel_position_1),
      .rsp_wheel_position_2 (rsp_wheel_position_2),
      .rsp_wheel_position_3 (rsp_wheel_position_3),
      .rsp_wheel_velocity_0 (rsp_wheel_velocity_0),
      .rsp_wheel_velocity_1 (rsp_wheel_velocity_1),
      .rsp_wheel_velocity_2 (rsp_wheel_velocity_2),
      .rsp_wheel_velocity_3 (rsp_wheel_velocity_3),
      .rsp_sample_taken     (rsp_sample_taken),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   wev_velocity_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_wheel_count_0    (req_wheel_count_0),
      .req_wheel_count_1    (req_wheel_count_1),
      .req_wheel_count_2    (req_wheel_count_2),
      .req_wheel_count_3    (req_wheel_count_3),
      .req_elapsed_us       (req_elapsed_us),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_wheel_position_0 (rsp_wheel_position_0),
      .rsp_wheel_position_1 (rsp_wheel_position_1),
      .rsp_wheel_position_2 (rsp_wheel_position_2),
      .rsp_wheel_position_3 (rsp_wheel_position_3),
      .rsp_wheel_velocity_0 (rsp_wheel_velocity_0),
      .rsp_wheel_velocity_1 (rsp_wheel_velocity_1),
      .rsp_wheel_velocity_2 (rsp_wheel_velocity_2),
      .rsp_wheel_velocity_3 (rsp_wheel_velocity_3),
      .rsp_sample_taken     (rsp_sample_taken),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .fail_count           (fail_count),
      .outstanding          (outstanding)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Note each result transfer for the stall generator
   always @(posedge clock) rsp_taken <= rsp_valid && !rsp_stall;

   // Hold each new result for a random number of cycles
   always @(negedge clock) begin
      if (rsp_taken)
         stall_armed = 1'b0;
      if (rsp_valid && !stall_armed) begin
         stall_left  = stall_on ? $urandom_range(0, 19) : 0;
         stall_armed = 1'b1;
      end
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0)
         stall_left = stall_left - 1;
   end

   // End the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one sample after a random gap and hold it until the transfer
   task automatic send_sample(input logic [wev_pkg::COUNT_W-1:0]   c0,
                              input logic [wev_pkg::COUNT_W-1:0]   c1,
                              input logic [wev_pkg::COUNT_W-1:0]   c2,
                              input logic [wev_pkg::COUNT_W-1:0]   c3,
                              input logic [wev_pkg::ELAPSED_W-1:0] elapsed);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_wheel_count_0 = c0;
      req_wheel_count_1 = c1;
      req_wheel_count_2 = c2;
      req_wheel_count_3 = c3;
      req_elapsed_us    = elapsed;
      req_valid         = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      last_raw[0] = c0;
      last_raw[1] = c1;
      last_raw[2] = c2;
      last_raw[3] = c3;
   endtask

   task automatic write_reg(input logic [wev_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [wev_pkg::CSR_DATA_W-1:0] data);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_data     = data;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Drain every outstanding result and let the block go idle
   task automatic settle();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_config();
      logic [wev_pkg::RPT_W-1:0]   rpt;
      logic [wev_pkg::ALPHA_W-1:0] alpha;
      case ($urandom_range(0, 4))
         0: rpt = '0;
         1: rpt = 1;
         2: rpt = '1;
         3: rpt = wev_pkg::RPT_RESET;
         default: rpt = $urandom;
      endcase
      case ($urandom_range(0, 4))
         0: alpha = '0;
         1: alpha = wev_pkg::ALPHA_ONE;
         2: alpha = wev_pkg::ALPHA_W'($urandom_range(65537, 131071));
         default: alpha = wev_pkg::ALPHA_W'($urandom_range(0, 65536));
      endcase
      // Unused upper data bits carry noise
      write_reg(wev_pkg::CSR_RAD_PER_TICK, rpt);
      write_reg(wev_pkg::CSR_FILTER_ALPHA, {15'($urandom), alpha});
      write_reg(wev_pkg::CSR_INVERT_MASK, {28'($urandom), 4'($urandom)});
   endtask

   // Mostly a random walk of the counters, with jumps, extremes and skips
   task automatic random_sample();
      logic [wev_pkg::COUNT_W-1:0]   c [wev_pkg::WHEELS];
      logic [wev_pkg::COUNT_W-1:0]   step;
      logic [wev_pkg::ELAPSED_W-1:0] e;
      int                            i;
      for (i = 0; i < wev_pkg::WHEELS; i++) begin
         case ($urandom_range(0, 9))
            0: c[i] = $urandom;
            1: begin
               case ($urandom_range(0, 3))
                  0: c[i] = 32'h7FFF_FFFF;
                  1: c[i] = 32'h8000_0000;
                  2: c[i] = '0;
                  default: c[i] = '1;
               endcase
            end
            default: begin
               step = $urandom_range(0, 1 << $urandom_range(0, 20));
               c[i] = $urandom_range(0, 1) ? last_raw[i] + step : last_raw[i] - step;
            end
         endcase
      end
      case ($urandom_range(0, 9))
         0: e = '0;
         1: e = wev_pkg::ELAPSED_W'($urandom);
         2: e = $urandom_range(0, 1) ? wev_pkg::ELAPSED_W'(1) : '1;
         default: e = wev_pkg::ELAPSED_W'($urandom_range(100, 20000));
      endcase
      send_sample(c[0], c[1], c[2], c[3], e);
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_wheel_count_0 = '0;
      req_wheel_count_1 = '0;
      req_wheel_count_2 = '0;
      req_wheel_count_3 = '0;
      req_elapsed_us    = '0;
      csr_write_en      = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      req_idle_on       = 1'b1;
      stall_on          = 1'b1;
      for (int i = 0; i < wev_pkg::WHEELS; i++)
         last_raw[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Default registers: skip from reset, saturation, wrap, longest interval
      send_sample(32'h0, 32'h0, 32'h0, 32'h0, 24'h0);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 24'h1);
      send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h1);
      send_sample(32'h0, 32'h0, 32'h0, 32'h0, 24'hFF_FFFF);
      send_sample(32'd100, -32'sd100, 32'd5000, -32'sd5000, 24'd1000);
      send_sample(32'd777, 32'd777, 32'd777, 32'd777, 24'h0);

      // Zero radians per tick, no smoothing, no inversion
      settle();
      write_reg(wev_pkg::CSR_RAD_PER_TICK, '0);
      write_reg(wev_pkg::CSR_FILTER_ALPHA, wev_pkg::CSR_DATA_W'(wev_pkg::ALPHA_ONE));
      write_reg(wev_pkg::CSR_INVERT_MASK, '0);
      send_sample(32'd1234, -32'sd1234, 32'h7FFF_FFFF, 32'h8000_0000, 24'd500);
      send_sample(32'd1, 32'd2, 32'd3, 32'd4, 24'h0);

      // Largest radians per tick, frozen filter, all wheels negated
      settle();
      write_reg(wev_pkg::CSR_RAD_PER_TICK, '1);
      write_reg(wev_pkg::CSR_FILTER_ALPHA, '0);
      write_reg(wev_pkg::CSR_INVERT_MASK, 32'hF);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 24'h1);
      send_sample(32'h0, 32'h0, 32'h0, 32'h0, 24'hFF_FFFF);
      send_sample(32'hAAAA_5555, 32'h5555_AAAA, 32'h8000_0000, 32'h7FFF_FFFF, 24'd3);

      // Alpha beyond one, smallest nonzero radians per tick
      settle();
      write_reg(wev_pkg::CSR_RAD_PER_TICK, 32'h1);
      write_reg(wev_pkg::CSR_FILTER_ALPHA, 32'h1_FFFF);
      write_reg(wev_pkg::CSR_INVERT_MASK, 32'h5);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'hFEDC_BA98, 24'd2);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 24'hFF_FFFF);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 24'h0);

      // Alpha just above one, mask on wheels 1 and 3
      settle();
      write_reg(wev_pkg::CSR_RAD_PER_TICK, 32'h1234_5678);
      write_reg(wev_pkg::CSR_FILTER_ALPHA, 32'h1_0001);
      write_reg(wev_pkg::CSR_INVERT_MASK, 32'hA);
      send_sample(32'd40000, -32'sd40000, 32'd123, -32'sd123, 24'd1000);
      send_sample(32'd41000, -32'sd39000, 32'd120, -32'sd126, 24'd1000);

      // Random phases, each under its own register setting, idle pattern and stall pattern
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         random_config();
         req_idle_on = ($urandom_range(0, 3) != 0);
         stall_on    = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < SAMPLES_PER_PHASE; n++)
            random_sample();
      end

      settle();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
